FILE: sv/flash_erase_range_planner_defines.svh
// Assertion macros shared by the erase planner modules.
`ifndef FLASH_ERASE_RANGE_PLANNER_DEFINES_SVH
`define FLASH_ERASE_RANGE_PLANNER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FEPL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FEPL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/fepl_pkg.sv
// Types, constants and register codes for the flash erase range planner.
package fepl_pkg;

	localparam int AddrBits  = 24;
	localparam int RangeBits = AddrBits + 1;
	// wide enough for address + length + a 31-bit sector mask
	localparam int WideBits  = 33;
	localparam int LogBits   = 5;
	localparam int OpBits    = 8;
	localparam int CfgTypes  = 4;
	localparam int KindBits  = 3;
	localparam int TypeBits  = 2;
	localparam int CountBits = 3;
	localparam int ApbAddrBits = 5;
	localparam int ApbDataBits = 32;

	localparam int MaxSectorTypesDef = 4;
	localparam int QueueDepthDef     = 2;

	localparam logic [WideBits-1:0] RangeMax = WideBits'((64'd1 << RangeBits) - 64'd1);

	localparam logic [CountBits-1:0]         SectorCountRst = 3'd1;
	localparam logic [LogBits*CfgTypes-1:0]  SectorLogsRst  = 20'd12;
	localparam logic [OpBits*CfgTypes-1:0]   SectorOpsRst   = 32'h0000_0020;
	localparam logic [RangeBits-1:0]         DeviceSizeRst  = 25'd16777216;
	localparam logic [OpBits-1:0]            ChipOpRst      = 8'hC7;

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_NEXT  = 1'b1
	} action_t;

	typedef enum logic [KindBits-1:0] {
		KIND_SECTOR   = 3'd0,
		KIND_CHIP     = 3'd1,
		KIND_NOTHING  = 3'd2,
		KIND_INVALID  = 3'd3,
		KIND_NO_RANGE = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		REG_SECTOR_COUNT = 3'd0,
		REG_SECTOR_LOGS  = 3'd1,
		REG_SECTOR_OPS   = 3'd2,
		REG_DEVICE_SIZE  = 3'd3,
		REG_CHIP_OPCODE  = 3'd4
	} reg_idx_t;

	// classification done by the front part
	typedef enum logic [1:0] {
		OP_NEXT  = 2'd0,
		OP_START = 2'd1,
		OP_CHIP  = 2'd2
	} op_t;

	typedef struct packed {
		action_t               action;
		logic [AddrBits-1:0]   address;
		logic [RangeBits-1:0]  length;
	} req_t;

	typedef struct packed {
		kind_t                 kind;
		logic [OpBits-1:0]     opcode;
		logic [AddrBits-1:0]   erase_address;
		logic [TypeBits-1:0]   type_index;
		logic                  last;
	} rsp_t;

	typedef struct packed {
		logic [CountBits-1:0]        sector_count;
		logic [LogBits*CfgTypes-1:0] sector_size_logs;
		logic [OpBits*CfgTypes-1:0]  sector_opcodes;
		logic [RangeBits-1:0]        device_size;
		logic [OpBits-1:0]           chip_erase_opcode;
	} cfg_t;

	typedef struct packed {
		op_t                  op;
		logic [RangeBits-1:0] start_addr;
		logic [RangeBits-1:0] end_addr;
	} entry_t;

endpackage

FILE: sv/fepl_front.sv
// Front part: accepts requests, widens start ranges and spots whole-chip erases.
module fepl_front (
	input  logic           clk,
	input  logic           arst_n,
	input  fepl_pkg::cfg_t cfg,
	input  logic           req_valid,
	output logic           req_ready,
	input  fepl_pkg::req_t req,
	output logic           ent_valid,
	input  logic           ent_ready,
	output fepl_pkg::entry_t ent
);
	import fepl_pkg::*;

	logic                  valid_s1;
	entry_t                ent_s1;
	logic [WideBits-1:0]   mask;
	logic [WideBits-1:0]   start_w;
	logic [WideBits-1:0]   end_w;
	logic [WideBits-1:0]   sum_w;
	entry_t                ent_d;
	logic                  take;

	assign req_ready = !valid_s1 || ent_ready;
	assign take      = req_valid && req_ready;

	always_comb begin
		// sector type 0 sets the widening granule; no types means no widening
		if (cfg.sector_count != '0) begin
			mask = (WideBits'(1) << cfg.sector_size_logs[LogBits-1:0]) - WideBits'(1);
		end else begin
			mask = '0;
		end
		start_w = WideBits'(req.address) & ~mask;
		sum_w   = WideBits'(req.address) + WideBits'(req.length) + mask;
		end_w   = sum_w & ~mask;
		if (end_w > RangeMax) begin
			end_w = RangeMax & ~mask;
		end
		ent_d.start_addr = start_w[RangeBits-1:0];
		ent_d.end_addr   = end_w[RangeBits-1:0];
		if (req.action == ACT_NEXT) begin
			ent_d.op = OP_NEXT;
		end else if (start_w == '0 && end_w[RangeBits-1:0] == cfg.device_size) begin
			ent_d.op = OP_CHIP;
		end else begin
			ent_d.op = OP_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ent_s1 <= ent_d;
		end
	end

	assign ent_valid = valid_s1;
	assign ent       = ent_s1;

endmodule

FILE: sv/fepl_queue.sv
// Short queue between the front and back parts.
module fepl_queue #(
	parameter int Depth = fepl_pkg::QueueDepthDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  fepl_pkg::entry_t push_ent,
	output logic             pop_valid,
	input  logic             pop_ready,
	output fepl_pkg::entry_t pop_ent
);
	import fepl_pkg::*;

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	entry_t            mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != CntW'(Depth);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_ent    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

`include "flash_erase_range_planner_defines.svh"

	`FEPL_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + CntW'(1), "queue count did not grow on push")
	`FEPL_ASSERT_NEXT(a_count_down, pop && !push, count_q == $past(count_q) - CntW'(1), "queue count did not shrink on pop")
	`FEPL_ASSERT_NOW(a_ptr_gap, count_q == '0, wr_ptr_q == rd_ptr_q, "empty queue with pointers apart")

endmodule

FILE: sv/fepl_back.sv
// Back part: holds the range state and plans one erase command per entry.
module fepl_back #(
	parameter int MaxSectorTypes = fepl_pkg::MaxSectorTypesDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fepl_pkg::cfg_t   cfg,
	input  logic             ent_valid,
	output logic             ent_ready,
	input  fepl_pkg::entry_t ent,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output fepl_pkg::rsp_t   rsp
);
	import fepl_pkg::*;

	logic [RangeBits-1:0] range_start_q;
	logic [RangeBits-1:0] range_end_q;
	logic                 range_active_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic [3:0]           n_eff;
	logic [RangeBits-1:0] cur_start;
	logic [RangeBits-1:0] cur_end;
	logic [WideBits-1:0]  cur_start_w;
	logic [WideBits-1:0]  cur_end_w;
	logic [MaxSectorTypes-1:0] hit;
	logic [WideBits-1:0]  sum_arr [MaxSectorTypes];
	logic [OpBits-1:0]    opc_arr [MaxSectorTypes];

	logic                 found;
	logic [WideBits-1:0]  sum_sel;
	logic [OpBits-1:0]    opc_sel;
	logic [TypeBits-1:0]  tidx_sel;
	logic                 done;

	logic                 pop;
	rsp_t                 rsp_d;
	logic [RangeBits-1:0] start_d;
	logic [RangeBits-1:0] end_d;
	logic                 active_d;

	assign ent_ready = !rsp_valid_q || rsp_ready;
	assign pop       = ent_valid && ent_ready;

	assign n_eff = (4'(cfg.sector_count) > 4'(MaxSectorTypes)) ?
		4'(MaxSectorTypes) : 4'(cfg.sector_count);

	// a start entry plans from its own fresh range
	assign cur_start   = (ent.op == OP_NEXT) ? range_start_q : ent.start_addr;
	assign cur_end     = (ent.op == OP_NEXT) ? range_end_q : ent.end_addr;
	assign cur_start_w = WideBits'(cur_start);
	assign cur_end_w   = WideBits'(cur_end);

	for (genvar t = 0; t < MaxSectorTypes; t++) begin : g_type
		logic [LogBits-1:0]  lg;
		logic [WideBits-1:0] size;
		if (t < CfgTypes) begin : g_cfg
			assign lg         = cfg.sector_size_logs[LogBits*t +: LogBits];
			assign opc_arr[t] = cfg.sector_opcodes[OpBits*t +: OpBits];
		end else begin : g_none
			assign lg         = '0;
			assign opc_arr[t] = '0;
		end
		assign size       = WideBits'(1) << lg;
		assign sum_arr[t] = cur_start_w + size;
		assign hit[t]     = (4'(t) < n_eff) && ((cur_start_w & (size - WideBits'(1))) == '0) &&
			(sum_arr[t] <= cur_end_w);
	end

	// highest fitting type wins
	always_comb begin
		found    = 1'b0;
		sum_sel  = '0;
		opc_sel  = '0;
		tidx_sel = '0;
		for (int t = 0; t < MaxSectorTypes; t++) begin
			if (hit[t]) begin
				found    = 1'b1;
				sum_sel  = sum_arr[t];
				opc_sel  = opc_arr[t];
				tidx_sel = TypeBits'(t);
			end
		end
	end

	assign done = sum_sel >= cur_end_w;

	always_comb begin
		rsp_d    = '{kind: KIND_NO_RANGE, opcode: '0, erase_address: '0, type_index: '0,
			last: 1'b0};
		start_d  = range_start_q;
		end_d    = range_end_q;
		active_d = range_active_q;
		unique case (ent.op)
			OP_CHIP: begin
				rsp_d.kind   = KIND_CHIP;
				rsp_d.opcode = cfg.chip_erase_opcode;
				rsp_d.last   = 1'b1;
				start_d      = ent.start_addr;
				end_d        = ent.end_addr;
				active_d     = 1'b0;
			end
			OP_START, OP_NEXT: begin
				if (ent.op == OP_NEXT && !range_active_q) begin
					rsp_d.kind = KIND_NO_RANGE;
				end else begin
					start_d             = cur_start;
					end_d               = cur_end;
					rsp_d.erase_address = cur_start[AddrBits-1:0];
					rsp_d.last          = 1'b1;
					active_d            = 1'b0;
					priority if (cur_start >= cur_end) begin
						rsp_d.kind = KIND_NOTHING;
					end else if (found) begin
						rsp_d.kind       = KIND_SECTOR;
						rsp_d.opcode     = opc_sel;
						rsp_d.type_index = tidx_sel;
						rsp_d.last       = done;
						start_d          = sum_sel[RangeBits-1:0];
						active_d         = !done;
					end else begin
						rsp_d.kind = KIND_INVALID;
					end
				end
			end
			default: begin
				rsp_d.kind = KIND_NO_RANGE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_start_q  <= '0;
			range_end_q    <= '0;
			range_active_q <= 1'b0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (pop) begin
				range_start_q  <= start_d;
				range_end_q    <= end_d;
				range_active_q <= active_d;
			end
			if (ent_ready) begin
				rsp_valid_q <= ent_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`include "flash_erase_range_planner_defines.svh"

	`FEPL_ASSERT_NEXT(a_last_ends, pop && rsp_d.last, !range_active_q, "range still active after last command")
	`FEPL_ASSERT_NEXT(a_more_keeps, pop && rsp_d.kind == KIND_SECTOR && !rsp_d.last, range_active_q, "range dropped before its end")
	`FEPL_ASSERT_NOW(a_chip_last, pop && ent.op == OP_CHIP, rsp_d.last && rsp_d.kind == KIND_CHIP, "chip erase not a final command")

endmodule

FILE: sv/flash_erase_range_planner.sv
// Top level of the flash erase range planner: configuration registers and part wiring.
//
// Plans SPI NOR erase commands for a byte range. Each request on the req channel
// (valid/ready) gives exactly one response on the rsp channel (valid/ready).
// A start request (action 0) widens address/length to sector type 0 bounds and
// answers with a chip erase when the range is the whole device, otherwise with the
// first sector erase. Each next request (action 1) answers with the following one.
// Registers sit on an APB-style port at byte address 4*i; write only while idle.
// A request is held in the front register, then the queue, then the output
// register before its response shows.
// Throughput: one request per cycle while rsp_ready holds; the back part plans a
// command combinationally from parallel compares over the sector types.
// A stalled rsp_ready fills the output register, then the two-entry queue, then
// the front register, after which req_ready falls; nothing is dropped.
// Reset clears the range state, empties the pipeline and loads register defaults
// (one 4 KiB type, opcode 0x20, 16 MiB device, chip erase 0xC7).
module flash_erase_range_planner #(
	parameter int MaxSectorTypes = fepl_pkg::MaxSectorTypesDef,
	parameter int QueueDepth     = fepl_pkg::QueueDepthDef
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [fepl_pkg::ApbAddrBits-1:0]   paddr,
	input  logic [fepl_pkg::ApbDataBits-1:0]   pwdata,
	output logic [fepl_pkg::ApbDataBits-1:0]   prdata,
	output logic                               pready,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  fepl_pkg::req_t                     req,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output fepl_pkg::rsp_t                     rsp
);
	import fepl_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	logic     f_valid;
	logic     f_ready;
	entry_t   f_ent;
	logic     b_valid;
	logic     b_ready;
	entry_t   b_ent;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ApbAddrBits-1:2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sector_count      <= SectorCountRst;
			cfg_q.sector_size_logs  <= SectorLogsRst;
			cfg_q.sector_opcodes    <= SectorOpsRst;
			cfg_q.device_size       <= DeviceSizeRst;
			cfg_q.chip_erase_opcode <= ChipOpRst;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SECTOR_COUNT: cfg_q.sector_count      <= pwdata[CountBits-1:0];
				REG_SECTOR_LOGS:  cfg_q.sector_size_logs  <= pwdata[LogBits*CfgTypes-1:0];
				REG_SECTOR_OPS:   cfg_q.sector_opcodes    <= pwdata[OpBits*CfgTypes-1:0];
				REG_DEVICE_SIZE:  cfg_q.device_size       <= pwdata[RangeBits-1:0];
				REG_CHIP_OPCODE:  cfg_q.chip_erase_opcode <= pwdata[OpBits-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SECTOR_COUNT: prdata = ApbDataBits'(cfg_q.sector_count);
			REG_SECTOR_LOGS:  prdata = ApbDataBits'(cfg_q.sector_size_logs);
			REG_SECTOR_OPS:   prdata = ApbDataBits'(cfg_q.sector_opcodes);
			REG_DEVICE_SIZE:  prdata = ApbDataBits'(cfg_q.device_size);
			REG_CHIP_OPCODE:  prdata = ApbDataBits'(cfg_q.chip_erase_opcode);
			default:          prdata = '0;
		endcase
	end

	fepl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.ent_valid (f_valid),
		.ent_ready (f_ready),
		.ent       (f_ent)
	);

	fepl_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_ent   (f_ent),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_ent    (b_ent)
	);

	fepl_back #(
		.MaxSectorTypes (MaxSectorTypes)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.ent_valid (b_valid),
		.ent_ready (b_ready),
		.ent       (b_ent),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
